FILE: rtl/volcrop_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// volcrop_pkg
// shared widths, register map, command and status types, register clamps
// ----------------------------------------------------------------------------
package volcrop_pkg;

   localparam int IMAGE_EDGE_W = 10;
   localparam int CHANNEL_W    = 5;
   localparam int CROP_EDGE_W  = 7;
   localparam int CROP_NUM_W   = 10;
   localparam int CENTER_W     = 9;
   localparam int ORIGIN_W     = 10;
   localparam int COUNT_W      = 6;
   localparam int CHAN_CNT_W   = 4;
   localparam int IMG_ADDR_W   = 31;
   localparam int CROP_ADDR_W  = 32;
   localparam int IMG_ACC_W    = 34;
   localparam int VOL_W        = 32;
   localparam int PADDR_W      = 4;
   localparam int PDATA_W      = 32;

   localparam logic [IMAGE_EDGE_W-1:0] MAX_IMAGE_EDGE   = 10'd512;
   localparam logic [CHANNEL_W-1:0]    MAX_CHANNELS     = 5'd16;
   localparam logic [CROP_EDGE_W-1:0]  MAX_CROP_EDGE    = 7'd64;
   localparam logic [IMAGE_EDGE_W-1:0] RESET_IMAGE_EDGE = 10'd64;
   localparam logic [CHANNEL_W-1:0]    RESET_CHANNELS   = 5'd1;
   localparam logic [CROP_EDGE_W-1:0]  RESET_CROP_EDGE  = 7'd8;

   // register indexes, byte address is four times the index
   localparam logic [1:0] REG_IMAGE_EDGE    = 2'd0;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] REG_CROP_EDGE     = 2'd2;

   // multiply-add steps of one element
   localparam logic [1:0] MAC_ROW   = 2'd0;
   localparam logic [1:0] MAC_PLANE = 2'd1;
   localparam logic [1:0] MAC_CHAN  = 2'd2;
   localparam logic [1:0] MAC_LAST  = 2'd3;

   typedef struct packed {
      logic [IMAGE_EDGE_W-1:0] image_edge;
      logic [CHANNEL_W-1:0]    channel_count;
      logic [CROP_EDGE_W-1:0]  crop_edge;
   } cfg_type;

   typedef struct packed {
      logic       start;
      logic       load;
      logic       mac;
      logic [1:0] mac_step;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_status_type;

   function automatic logic [IMAGE_EDGE_W-1:0] clamp_image_edge(
      input logic [IMAGE_EDGE_W-1:0] v);
      logic [IMAGE_EDGE_W-1:0] r;
      if (v == '0) begin
         r = IMAGE_EDGE_W'(1);
      end else if (v > MAX_IMAGE_EDGE) begin
         r = MAX_IMAGE_EDGE;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [CHANNEL_W-1:0] clamp_channels(input logic [CHANNEL_W-1:0] v);
      logic [CHANNEL_W-1:0] r;
      if (v == '0) begin
         r = CHANNEL_W'(1);
      end else if (v > MAX_CHANNELS) begin
         r = MAX_CHANNELS;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [CROP_EDGE_W-1:0] clamp_crop_edge(
      input logic [CROP_EDGE_W-1:0] v);
      logic [CROP_EDGE_W-1:0] r;
      if (v == '0) begin
         r = CROP_EDGE_W'(1);
      end else if (v > MAX_CROP_EDGE) begin
         r = MAX_CROP_EDGE;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/volcrop_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// volcrop_csr
// configuration registers behind the apb port, clamped copies to the datapath
// ----------------------------------------------------------------------------
module volcrop_csr
   import volcrop_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   logic [IMAGE_EDGE_W-1:0] image_edge_ff;
   logic [CHANNEL_W-1:0]    channel_count_ff;
   logic [CROP_EDGE_W-1:0]  crop_edge_ff;
   logic [1:0]              reg_index;
   logic                    wr_en;

   assign reg_index = paddr[3:2];
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_edge_ff    <= RESET_IMAGE_EDGE;
         channel_count_ff <= RESET_CHANNELS;
         crop_edge_ff     <= RESET_CROP_EDGE;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_IMAGE_EDGE:    image_edge_ff    <= pwdata[IMAGE_EDGE_W-1:0];
            REG_CHANNEL_COUNT: channel_count_ff <= pwdata[CHANNEL_W-1:0];
            REG_CROP_EDGE:     crop_edge_ff     <= pwdata[CROP_EDGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_index)
         REG_IMAGE_EDGE:    prdata = PDATA_W'(image_edge_ff);
         REG_CHANNEL_COUNT: prdata = PDATA_W'(channel_count_ff);
         REG_CROP_EDGE:     prdata = PDATA_W'(crop_edge_ff);
         default:           prdata = '0;
      endcase
   end

   assign cfg.image_edge    = clamp_image_edge(image_edge_ff);
   assign cfg.channel_count = clamp_channels(channel_count_ff);
   assign cfg.crop_edge     = clamp_crop_edge(crop_edge_ff);

endmodule
`default_nettype wire

FILE: rtl/volcrop_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// volcrop_ctrl
// controller: request decode, multiply-add sequencing, response valid
// ----------------------------------------------------------------------------
module volcrop_ctrl
   import volcrop_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_kind,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] mac_step_ff, mac_step_in;
   logic       active_ff, active_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      mac_step_in  = mac_step_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      cmd.mac_step = mac_step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!req_kind) begin
                  cmd.start = 1'b1;
                  active_in = 1'b1;
               end else if (active_ff) begin
                  cmd.load    = 1'b1;
                  mac_step_in = MAC_ROW;
                  state_in    = S_CALC;
               end
            end
         end
         S_CALC: begin
            cmd.mac     = 1'b1;
            mac_step_in = mac_step_ff + 2'd1;
            if (mac_step_ff == MAC_LAST) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (status.last) begin
                  active_in = 1'b0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mac_step_ff  <= MAC_ROW;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mac_step_ff  <= mac_step_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/volcrop_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// volcrop_dp
// datapath: crop origin and counters, three multiply-add lanes for the
// source address, the volume size and the destination address, result register
// ----------------------------------------------------------------------------
module volcrop_dp
   import volcrop_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   input  wire logic [CROP_NUM_W-1:0] req_crop_number,
   input  wire logic [CENTER_W-1:0]   req_center_x,
   input  wire logic [CENTER_W-1:0]   req_center_y,
   input  wire logic [CENTER_W-1:0]   req_center_z,
   output logic      [IMG_ADDR_W-1:0] rsp_image_address,
   output logic     [CROP_ADDR_W-1:0] rsp_crop_address,
   output logic                       rsp_in_range,
   output logic                       rsp_last
);

   logic signed [ORIGIN_W-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [CROP_NUM_W-1:0]      crop_ff;
   logic [COUNT_W-1:0]         count_x_ff, count_y_ff, count_z_ff;
   logic [COUNT_W-1:0]         count_x_in, count_y_in, count_z_in;
   logic [CHAN_CNT_W-1:0]      count_c_ff, count_c_in;

   logic signed [IMG_ACC_W-1:0] img_acc_ff, img_acc_in;
   logic [VOL_W-1:0]            vol_acc_ff, vol_acc_in;
   logic [CROP_ADDR_W-1:0]      crop_acc_ff, crop_acc_in;

   logic [IMG_ADDR_W-1:0]  image_address_ff;
   logic [CROP_ADDR_W-1:0] crop_address_ff;
   logic                   in_range_ff, last_ff;

   logic [ORIGIN_W-1:0]         half;
   logic signed [ORIGIN_W:0]    ix, iy, iz;
   logic signed [ORIGIN_W:0]    edge_s, chan_s, img_mult;
   logic signed [IMG_ACC_W-1:0] img_addend, img_prod;
   logic [IMAGE_EDGE_W-1:0]     vol_mult;
   logic [VOL_W-1:0]            vol_prod;
   logic [CROP_EDGE_W-1:0]      crop_mult;
   logic [CROP_ADDR_W-1:0]      crop_addend, crop_prod;
   logic                        in_range;
   logic                        wrap_c, wrap_z, wrap_y, wrap_x;

   assign half = ORIGIN_W'(cfg.crop_edge[CROP_EDGE_W-1:1]);

   assign ix = $signed({origin_x_ff[ORIGIN_W-1], origin_x_ff} + (ORIGIN_W+1)'(count_x_ff));
   assign iy = $signed({origin_y_ff[ORIGIN_W-1], origin_y_ff} + (ORIGIN_W+1)'(count_y_ff));
   assign iz = $signed({origin_z_ff[ORIGIN_W-1], origin_z_ff} + (ORIGIN_W+1)'(count_z_ff));

   assign edge_s = $signed({1'b0, cfg.image_edge});
   assign chan_s = $signed((ORIGIN_W+1)'(cfg.channel_count));

   // source address lane
   always_comb begin
      img_mult   = edge_s;
      img_addend = '0;
      case (cmd.mac_step)
         MAC_ROW: begin
            img_mult   = edge_s;
            img_addend = IMG_ACC_W'(iy);
         end
         MAC_PLANE: begin
            img_mult   = edge_s;
            img_addend = IMG_ACC_W'(iz);
         end
         MAC_CHAN: begin
            img_mult   = chan_s;
            img_addend = IMG_ACC_W'(count_c_ff);
         end
         default: begin
            img_mult   = edge_s;
            img_addend = '0;
         end
      endcase
   end

   assign img_prod = img_acc_ff * img_mult;

   // volume size lane
   always_comb begin
      case (cmd.mac_step)
         MAC_CHAN: vol_mult = IMAGE_EDGE_W'(cfg.channel_count);
         default:  vol_mult = cfg.image_edge;
      endcase
   end

   assign vol_prod = vol_acc_ff * VOL_W'(vol_mult);

   // destination address lane
   always_comb begin
      crop_mult   = cfg.crop_edge;
      crop_addend = '0;
      case (cmd.mac_step)
         MAC_ROW:   crop_addend = CROP_ADDR_W'(count_x_ff);
         MAC_PLANE: crop_addend = CROP_ADDR_W'(count_y_ff);
         MAC_CHAN:  crop_addend = CROP_ADDR_W'(count_z_ff);
         default: begin
            crop_mult   = CROP_EDGE_W'(cfg.channel_count);
            crop_addend = CROP_ADDR_W'(count_c_ff);
         end
      endcase
   end

   assign crop_prod = crop_acc_ff * CROP_ADDR_W'(crop_mult);

   always_comb begin
      img_acc_in  = img_acc_ff;
      vol_acc_in  = vol_acc_ff;
      crop_acc_in = crop_acc_ff;
      if (cmd.load) begin
         img_acc_in  = IMG_ACC_W'(ix);
         vol_acc_in  = VOL_W'(cfg.image_edge);
         crop_acc_in = CROP_ADDR_W'(crop_ff);
      end else if (cmd.mac) begin
         crop_acc_in = crop_addend + crop_prod;
         if (cmd.mac_step != MAC_LAST) begin
            img_acc_in = img_addend + img_prod;
            vol_acc_in = vol_prod;
         end
      end
   end

   assign in_range = ~img_acc_ff[IMG_ACC_W-1] &
                     (img_acc_ff[IMG_ACC_W-2:0] < (IMG_ACC_W-1)'(vol_acc_ff));

   // counter wraps, channel innermost then z, y, x
   assign wrap_c = (({1'b0, count_c_ff}) + 5'd1) >= cfg.channel_count;
   assign wrap_z = wrap_c & ((({1'b0, count_z_ff}) + 7'd1) >= cfg.crop_edge);
   assign wrap_y = wrap_z & ((({1'b0, count_y_ff}) + 7'd1) >= cfg.crop_edge);
   assign wrap_x = wrap_y & ((({1'b0, count_x_ff}) + 7'd1) >= cfg.crop_edge);

   assign status.last = wrap_x;

   always_comb begin
      count_c_in = wrap_c ? '0 : count_c_ff + 4'd1;
      count_z_in = wrap_c ? (wrap_z ? '0 : count_z_ff + 6'd1) : count_z_ff;
      count_y_in = wrap_z ? (wrap_y ? '0 : count_y_ff + 6'd1) : count_y_ff;
      count_x_in = wrap_y ? (wrap_x ? '0 : count_x_ff + 6'd1) : count_x_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         crop_ff     <= '0;
         count_x_ff  <= '0;
         count_y_ff  <= '0;
         count_z_ff  <= '0;
         count_c_ff  <= '0;
      end else if (cmd.start) begin
         origin_x_ff <= $signed(ORIGIN_W'(req_center_x) - half);
         origin_y_ff <= $signed(ORIGIN_W'(req_center_y) - half);
         origin_z_ff <= $signed(ORIGIN_W'(req_center_z) - half);
         crop_ff     <= req_crop_number;
         count_x_ff  <= '0;
         count_y_ff  <= '0;
         count_z_ff  <= '0;
         count_c_ff  <= '0;
      end else if (cmd.emit) begin
         count_x_ff <= count_x_in;
         count_y_ff <= count_y_in;
         count_z_ff <= count_z_in;
         count_c_ff <= count_c_in;
      end
   end

   always_ff @(posedge clock) begin
      img_acc_ff  <= img_acc_in;
      vol_acc_ff  <= vol_acc_in;
      crop_acc_ff <= crop_acc_in;
      if (cmd.emit) begin
         image_address_ff <= in_range ? img_acc_ff[IMG_ADDR_W-1:0] : '0;
         crop_address_ff  <= crop_acc_ff;
         in_range_ff      <= in_range;
         last_ff          <= wrap_x;
      end
   end

   assign rsp_image_address = image_address_ff;
   assign rsp_crop_address  = crop_address_ff;
   assign rsp_in_range      = in_range_ff;
   assign rsp_last          = last_ff;

endmodule
`default_nettype wire

FILE: rtl/volume_crop_address_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// volume_crop_address_generator_top
// gather address generator for cubic crops of a channel-interleaved volume
//
// req channel: a request with req_kind 0 starts a crop (crop number and
// center) and gives no response; req_kind 1 steps to the next element and
// gives one response while a crop is open, none otherwise.
// rsp channel: source address, destination address, in_range and last,
// last marking the final element of the crop.
// a start request leaves the controller idle. a step request is taken, then
// the multiply-add steps row, plane, channel and last run, the source and
// volume-size lanes on all but the last, the destination lane on all; the
// emit state loads the response register once it frees, then req_ready rises.
// a finished response waits in its own register, so the next request is
// taken while the receiver stalls; its result is held in the datapath until
// the response register frees.
// reset (synchronous) loads the register defaults (image edge 64, one
// channel, crop edge 8) and closes any open crop.
// apb: image_edge at 0x0, channel_count at 0x4, crop_edge at 0x8
// ----------------------------------------------------------------------------
module volume_crop_address_generator_top
   import volcrop_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_kind,
   input  wire logic [CROP_NUM_W-1:0]  req_crop_number,
   input  wire logic [CENTER_W-1:0]    req_center_x,
   input  wire logic [CENTER_W-1:0]    req_center_y,
   input  wire logic [CENTER_W-1:0]    req_center_z,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [IMG_ADDR_W-1:0]  rsp_image_address,
   output logic      [CROP_ADDR_W-1:0] rsp_crop_address,
   output logic                        rsp_in_range,
   output logic                        rsp_last,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [PADDR_W-1:0]     paddr,
   input  wire logic [PDATA_W-1:0]     pwdata,
   output logic      [PDATA_W-1:0]     prdata,
   output logic                        pready
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   volcrop_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   volcrop_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   volcrop_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_crop_number   (req_crop_number),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_center_z      (req_center_z),
      .rsp_image_address (rsp_image_address),
      .rsp_crop_address  (rsp_crop_address),
      .rsp_in_range      (rsp_in_range),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire
